// ----- rtl/stable_min_priority_queue_unit_assert.svh -----
// Assertion macros used by the priority queue top level.
`ifndef STABLE_MIN_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define STABLE_MIN_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Condition holds in the same cycle as the antecedent.
`define SMPQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smpq assertion failed");

// Condition holds in the cycle after the antecedent.
`define SMPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smpq assertion failed");

`endif

// ----- rtl/smpq_pkg.sv -----
// Types and constants of the stable minimum priority queue.
package smpq_pkg;

   // Number of cells in the sorted chain.
   localparam int CAPACITY = 64;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int OCC_W    = 7;
   localparam int WORD_W   = 32;

   typedef enum logic [0:0] {
      REQ_ENQUEUE = 1'b0,
      REQ_DEQUEUE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_DEQUEUED = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_POP    = 2'd2
   } cell_op_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] key;
      logic signed [WORD_W-1:0] value;
   } entry_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      cell_op_type op;
      entry_type   new_entry;
   } cell_ctrl_type;

endpackage

// ----- rtl/smpq_cell.sv -----
// One cell of the sorted chain: holds one entry and shifts with its neighbours.
module smpq_cell
   import smpq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occupied,
   input  entry_type     prev_entry,
   input  logic          prev_gt,
   input  entry_type     next_entry,
   output entry_type     entry,
   output logic          gt
);

   entry_type entry_ff;
   entry_type entry_in;

   // An empty cell counts as holding an infinitely large key.
   assign gt    = !occupied || ($signed(entry_ff.key) > $signed(ctrl.new_entry.key));
   assign entry = entry_ff;

   // Insert: cells after the insertion point take their left neighbour's entry,
   // the first cell with a greater key takes the new one. Pop shifts left.
   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.op)
         CELL_HOLD: begin
            entry_in = entry_ff;
         end
         CELL_INSERT: begin
            if (prev_gt) begin
               entry_in = prev_entry;
            end else if (gt) begin
               entry_in = ctrl.new_entry;
            end
         end
         CELL_POP: begin
            entry_in = next_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- rtl/stable_min_priority_queue_unit.sv -----
// Top level of the stable minimum priority queue: request decode, cell chain, result register.
// The queue accepts one request per clock cycle and returns its result in the cycle after
// the request transfer, from an output register. A new request is taken only when that
// register is free or its result transfers in the same cycle, so a stalled result holds
// off the next request. Entries live in a row of cells kept sorted by signed
// key; every cell compares its key with the broadcast key of an enqueue in the same
// cycle, so an insertion or a removal of the head takes no longer at any occupancy.
// Entries with equal keys leave in arrival order. There is no clearing pass
// after reset: the entry count alone marks which cells hold data.
`include "stable_min_priority_queue_unit_assert.svh"

module stable_min_priority_queue_unit
   import smpq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // key [31:0], value [63:32]
   input  logic [0:0]  req_tuser,   // req_type [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // out_value [31:0], out_key [63:32], occupancy [70:64]
   output logic [1:0]  rsp_tuser    // status [1:0]
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   entry_type        rsp_entry_ff;
   entry_type        rsp_entry_in;
   status_type       rsp_status_ff;
   status_type       rsp_status_in;
   logic [OCC_W-1:0] rsp_occ_ff;
   logic [OCC_W-1:0] rsp_occ_in;

   logic             req_accept;
   req_kind_type     req_kind;
   entry_type        req_entry;
   logic             is_full;
   logic             is_empty;
   cell_ctrl_type    ctrl;

   entry_type        cell_entry [CAPACITY];
   logic             cell_gt    [CAPACITY];

   // Request decode.
   assign req_tready      = !rsp_valid_ff || rsp_tready;
   assign req_accept      = req_tvalid && req_tready;
   assign req_kind        = req_kind_type'(req_tuser[0]);
   assign req_entry.key   = req_tdata[31:0];
   assign req_entry.value = req_tdata[63:32];
   assign is_full         = (count_ff == CNT_W'(CAPACITY));
   assign is_empty        = (count_ff == '0);

   // Command for the chain and next entry count.
   always_comb begin
      ctrl.op        = CELL_HOLD;
      ctrl.new_entry = req_entry;
      count_in       = count_ff;
      if (req_accept) begin
         unique case (req_kind)
            REQ_ENQUEUE: begin
               if (!is_full) begin
                  ctrl.op  = CELL_INSERT;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            REQ_DEQUEUE: begin
               if (!is_empty) begin
                  ctrl.op  = CELL_POP;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            default: begin
               ctrl.op = CELL_HOLD;
            end
         endcase
      end
   end

   // The sorted chain of cells; cell zero holds the smallest key.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      occupied;
      entry_type prev_entry;
      logic      prev_gt;
      entry_type next_entry;

      assign occupied = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign prev_entry = req_entry;
         assign prev_gt    = 1'b0;
      end else begin : g_mid
         assign prev_entry = cell_entry[i-1];
         assign prev_gt    = cell_gt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_entry = cell_entry[i];
      end else begin : g_inner
         assign next_entry = cell_entry[i+1];
      end

      smpq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (occupied),
         .prev_entry (prev_entry),
         .prev_gt    (prev_gt),
         .next_entry (next_entry),
         .entry      (cell_entry[i]),
         .gt         (cell_gt[i])
      );
   end

   // Result formed at the request transfer.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_entry_in  = rsp_entry_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_occ_in   = OCC_W'(count_in);
         unique case (req_kind)
            REQ_ENQUEUE: begin
               rsp_entry_in  = '0;
               rsp_status_in = is_full ? ST_FULL : ST_ENQUEUED;
            end
            REQ_DEQUEUE: begin
               if (is_empty) begin
                  rsp_entry_in.key   = '0;
                  rsp_entry_in.value = '1;
                  rsp_status_in      = ST_EMPTY;
               end else begin
                  rsp_entry_in  = cell_entry[0];
                  rsp_status_in = ST_DEQUEUED;
               end
            end
            default: begin
               rsp_entry_in  = '0;
               rsp_status_in = ST_FULL;
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      rsp_entry_ff  <= rsp_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_occ_ff, rsp_entry_ff.key, rsp_entry_ff.value};
   assign rsp_tuser  = rsp_status_ff;

   // Checks on the entry count and the empty result.
   `SMPQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `SMPQ_ASSERT_NEXT(a_enq_grows, clock, reset,
      req_accept && req_kind == REQ_ENQUEUE && !is_full,
      count_ff == $past(count_ff) + CNT_W'(1))
   `SMPQ_ASSERT_NEXT(a_deq_shrinks, clock, reset,
      req_accept && req_kind == REQ_DEQUEUE && !is_empty,
      count_ff == $past(count_ff) - CNT_W'(1))
   `SMPQ_ASSERT_SAME(a_empty_result, clock, reset,
      rsp_valid_ff && rsp_status_ff == ST_EMPTY,
      rsp_occ_ff == '0 && rsp_entry_ff.value == '1)

endmodule

// ----- tb/tb_stable_min_priority_queue_unit.sv -----
// Self-checking testbench for the stable minimum priority queue: directed table, random traffic.
module tb_stable_min_priority_queue_unit;
   import smpq_pkg::*;

   // One result as it leaves the queue, laid out field by field.
   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic [WORD_W-1:0] key;
      status_type        status;
      logic [OCC_W-1:0]  occupancy;
   } pq_result_type;

   // One row of the directed table; fixed rows carry their result typed in.
   typedef struct packed {
      req_kind_type      kind;
      logic [WORD_W-1:0] key;
      logic [WORD_W-1:0] value;
      bit                fixed;
      pq_result_type     reply;
   } stim_row_type;

   // Traffic mixes used by the random part to reach both full and empty.
   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_BALANCED
   } traffic_mix_type;

   localparam int          DIRECTED_ROWS   = 23;
   localparam int          ITEMS_PER_PHASE = 300;
   localparam int          CYCLE_LIMIT     = 400000;
   localparam int          MAX_REPORTED    = 10;
   localparam int          SEND_IDLE_PCT [4] = '{0, 84, 0, 32};
   localparam int          STALL_PCT     [4] = '{0, 0, 84, 32};
   localparam logic [31:0] EDGE_KEYS     [4] =
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   // Predictor state: entries kept sorted by signed key, ties in arrival order.
   entry_type     model_entries[$];
   pq_result_type pending_replies[$];

   int sender_idle_pct = 0;
   int stall_pct       = 0;
   int mismatch_count  = 0;
   int results_checked = 0;
   int enqueue_count   = 0;
   int dequeue_count   = 0;
   int full_refusals   = 0;
   int empty_dequeues  = 0;
   int peak_occupancy  = 0;
   int cycle_count     = 0;

   // Directed table: empty queue after reset, key and value extremes, ties and refills.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{REQ_DEQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b1,
        '{32'hFFFF_FFFF, 32'h0, ST_EMPTY, 7'd0}},
      '{REQ_ENQUEUE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, '{32'h0, 32'h0, ST_ENQUEUED, 7'd1}},
      '{REQ_ENQUEUE, 32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h0, 32'h0, ST_ENQUEUED, 7'd2}},
      '{REQ_ENQUEUE, 32'h0000_0005, 32'h0000_0001, 1'b1, '{32'h0, 32'h0, ST_ENQUEUED, 7'd3}},
      '{REQ_ENQUEUE, 32'h0000_0005, 32'h0000_0002, 1'b1, '{32'h0, 32'h0, ST_ENQUEUED, 7'd4}},
      '{REQ_ENQUEUE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0, 32'h0, ST_ENQUEUED, 7'd5}},
      '{REQ_ENQUEUE, 32'h0000_0005, 32'h0000_0003, 1'b1, '{32'h0, 32'h0, ST_ENQUEUED, 7'd6}},
      '{REQ_ENQUEUE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0, 32'h0, ST_ENQUEUED, 7'd7}},
      '{REQ_DEQUEUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
        '{32'h8000_0000, 32'h8000_0000, ST_DEQUEUED, 7'd6}},
      '{REQ_DEQUEUE, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, '0},
      '{REQ_DEQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{REQ_DEQUEUE, 32'h0000_0005, 32'h0000_0005, 1'b0, '0},
      '{REQ_ENQUEUE, 32'h0000_0005, 32'h0000_0004, 1'b0, '0},
      '{REQ_ENQUEUE, 32'h8000_0000, 32'h5555_AAAA, 1'b0, '0},
      '{REQ_DEQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{REQ_DEQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{REQ_DEQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{REQ_DEQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{REQ_DEQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{REQ_DEQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b1,
        '{32'hFFFF_FFFF, 32'h0, ST_EMPTY, 7'd0}},
      '{REQ_DEQUEUE, 32'hAAAA_5555, 32'h5555_AAAA, 1'b1,
        '{32'hFFFF_FFFF, 32'h0, ST_EMPTY, 7'd0}},
      '{REQ_ENQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0, 32'h0, ST_ENQUEUED, 7'd1}},
      '{REQ_DEQUEUE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
        '{32'h0, 32'h0, ST_DEQUEUED, 7'd0}}
   };

   stable_min_priority_queue_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // key [31:0], value [63:32]
      .req_tuser  (req_tuser),   // req_type [0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // out_value [31:0], out_key [63:32], occupancy [70:64]
      .rsp_tuser  (rsp_tuser)    // status [1:0]
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Applies one request to the sorted store and returns the result it must produce.
   function automatic pq_result_type predict_queue_op(input req_kind_type kind,
                                                      input logic [WORD_W-1:0] key,
                                                      input logic [WORD_W-1:0] value);
      pq_result_type reply;
      entry_type     item;
      int            slot;
      reply = '{32'h0, 32'h0, ST_ENQUEUED, '0};
      if (kind == REQ_ENQUEUE) begin
         if (model_entries.size() >= CAPACITY) begin
            reply.status = ST_FULL;
            full_refusals++;
         end else begin
            item.key   = key;
            item.value = value;
            // The new entry goes behind every entry whose key is not larger.
            slot = 0;
            while (slot < model_entries.size() && !(model_entries[slot].key > item.key))
               slot++;
            model_entries.insert(slot, item);
            enqueue_count++;
         end
      end else if (model_entries.size() == 0) begin
         reply.value  = 32'hFFFF_FFFF;
         reply.status = ST_EMPTY;
         empty_dequeues++;
      end else begin
         item         = model_entries.pop_front();
         reply.value  = item.value;
         reply.key    = item.key;
         reply.status = ST_DEQUEUED;
         dequeue_count++;
      end
      reply.occupancy = OCC_W'(model_entries.size());
      if (model_entries.size() > peak_occupancy)
         peak_occupancy = model_entries.size();
      return reply;
   endfunction

   // Keys crowd around zero so that ties are common, with the extremes mixed in.
   function automatic logic [WORD_W-1:0] pick_key();
      case ($urandom_range(9))
         0, 1, 2, 3: return 32'($urandom_range(4)) - 32'd2;
         4:          return EDGE_KEYS[$urandom_range(3)];
         default:    return $urandom();
      endcase
   endfunction

   // Offers one request, waits for its transfer and records the result it should give.
   // Called and left at a falling edge.
   task automatic issue_request(input req_kind_type kind, input logic [WORD_W-1:0] key,
                                input logic [WORD_W-1:0] value, input bit fixed,
                                input pq_result_type fixed_reply);
      pq_result_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {value, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_queue_op(kind, key, value);
      pending_replies.push_back(fixed ? fixed_reply : predicted);
      @(negedge clock);
   endtask

   // Receiver: stalls at the rate of the current phase.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Result checker: every result transfer is matched against the oldest prediction.
   always @(posedge clock) begin
      pq_result_type seen;
      pq_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.value     = rsp_tdata[31:0];
         seen.key       = rsp_tdata[63:32];
         seen.occupancy = rsp_tdata[70:64];
         seen.status    = status_type'(rsp_tuser);
         if (pending_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED)
               $display("unexpected result: value %h key %h status %0d occupancy %0d",
                        seen.value, seen.key, seen.status, seen.occupancy);
         end else begin
            want = pending_replies.pop_front();
            results_checked++;
            if (seen.value !== want.value || seen.key !== want.key ||
                seen.status !== want.status || seen.occupancy !== want.occupancy) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTED)
                  $display({"result %0d differs: expected value %h key %h status %0d ",
                            "occupancy %0d, got value %h key %h status %0d occupancy %0d"},
                           results_checked, want.value, want.key, want.status,
                           want.occupancy, seen.value, seen.key, seen.status,
                           seen.occupancy);
            end
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_replies.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Stimulus: reset, directed table, then random traffic over four phases of sender idling and receiver stalls.
   initial begin
      traffic_mix_type   mix;
      int                burst_left;
      bit                enqueue;
      req_kind_type      kind;
      logic [WORD_W-1:0] key;
      logic [WORD_W-1:0] value;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      mix        = MIX_BALANCED;
      burst_left = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed rows, with no idling on either side.
      for (int row = 0; row < DIRECTED_ROWS; row++)
         issue_request(directed_rows[row].kind, directed_rows[row].key,
                       directed_rows[row].value, directed_rows[row].fixed,
                       directed_rows[row].reply);

      // Random traffic in bursts that lean towards filling or draining the queue, or balance the two.
      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct = SEND_IDLE_PCT[phase];
         stall_pct       = STALL_PCT[phase];
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (burst_left == 0) begin
               mix        = traffic_mix_type'($urandom_range(2));
               burst_left = $urandom_range(8, 90);
            end
            burst_left--;
            case (mix)
               MIX_FILL:  enqueue = ($urandom_range(99) < 90);
               MIX_DRAIN: enqueue = ($urandom_range(99) < 10);
               default:   enqueue = 1'($urandom_range(1));
            endcase
            kind  = enqueue ? REQ_ENQUEUE : REQ_DEQUEUE;
            key   = enqueue ? pick_key() : 32'($urandom());
            value = $urandom();
            issue_request(kind, key, value, 1'b0, '0);
         end
      end
      req_tvalid <= 1'b0;

      // Let every outstanding result arrive, then give a stray one time to show up.
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d enqueues, %0d dequeues, %0d refusals while full, %0d on empty",
               enqueue_count, dequeue_count, full_refusals, empty_dequeues);
      $display("peak occupancy %0d of %0d, %0d results checked, %0d mismatches",
               peak_occupancy, CAPACITY, results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
